>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the three-wire serial master.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME_CYCLE(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT_CYCLE(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("next-cycle check failed");

`endif

>>> design/rtcsm_pkg.sv
// ----------------------------------------------------------------------------
// rtcsm_pkg
// Types and constants shared by the three-wire serial master.
// ----------------------------------------------------------------------------
package rtcsm_pkg;

	// Largest number of bytes moved by one burst transfer.
	localparam int unsigned MAX_BURST_BYTES = 8;

	// Bits of the op field.
	localparam int unsigned OP_BURST_BIT = 0;
	localparam int unsigned OP_WRITE_BIT = 1;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_READ_FLAG           = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WRITE_FLAG          = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PROTECT_COMMAND     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PROTECT_SET_VALUE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PROTECT_CLEAR_VALUE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_BURST_COMMAND       = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD_TICKS   = 3'd6;

	// Configuration reset values.
	localparam logic [7:0] RST_READ_FLAG           = 8'd1;
	localparam logic [7:0] RST_WRITE_FLAG          = 8'd0;
	localparam logic [7:0] RST_PROTECT_COMMAND     = 8'd142;
	localparam logic [7:0] RST_PROTECT_SET_VALUE   = 8'd128;
	localparam logic [7:0] RST_PROTECT_CLEAR_VALUE = 8'd0;
	localparam logic [7:0] RST_BURST_COMMAND       = 8'd190;
	localparam logic [7:0] RST_HALF_PERIOD_TICKS   = 8'd1;

	typedef struct packed {
		logic [7:0] read_flag;
		logic [7:0] write_flag;
		logic [7:0] protect_command;
		logic [7:0] protect_set_value;
		logic [7:0] protect_clear_value;
		logic [7:0] burst_command;
		logic [7:0] half_period_ticks;
	} cfg_t;

	// One input item: one time tick of the pin sequencer.
	typedef struct packed {
		logic        start_req;
		logic [1:0]  op;
		logic [7:0]  address;
		logic [3:0]  count;
		logic [63:0] write_data;
		logic        data_pin_in;
	} tick_t;

	// One result item: pin levels and status for one tick.
	typedef struct packed {
		logic        chip_enable;
		logic        serial_clock;
		logic        data_pin_out;
		logic        data_drive;
		logic        busy_res;
		logic        done_res;
		logic [63:0] read_data;
	} pins_t;

endpackage

>>> design/rtcsm_ifs.sv
// ----------------------------------------------------------------------------
// rtcsm channel interfaces
// Valid/ready channels for tick items and pin result items.
// ----------------------------------------------------------------------------
interface rtcsm_tick_if;
	logic              valid;
	logic              ready;
	rtcsm_pkg::tick_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rtcsm_pins_if;
	logic              valid;
	logic              ready;
	rtcsm_pkg::pins_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> design/rtcsm_cfg.sv
// ----------------------------------------------------------------------------
// rtcsm_cfg
// Configuration register bank with a plain indexed write port.
// ----------------------------------------------------------------------------
module rtcsm_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [rtcsm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [7:0]                          cfg_data,
	output rtcsm_pkg::cfg_t                     cfg
);

	rtcsm_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.read_flag           <= rtcsm_pkg::RST_READ_FLAG;
			cfg_q.write_flag          <= rtcsm_pkg::RST_WRITE_FLAG;
			cfg_q.protect_command     <= rtcsm_pkg::RST_PROTECT_COMMAND;
			cfg_q.protect_set_value   <= rtcsm_pkg::RST_PROTECT_SET_VALUE;
			cfg_q.protect_clear_value <= rtcsm_pkg::RST_PROTECT_CLEAR_VALUE;
			cfg_q.burst_command       <= rtcsm_pkg::RST_BURST_COMMAND;
			cfg_q.half_period_ticks   <= rtcsm_pkg::RST_HALF_PERIOD_TICKS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rtcsm_pkg::CFG_READ_FLAG:           cfg_q.read_flag           <= cfg_data;
				rtcsm_pkg::CFG_WRITE_FLAG:          cfg_q.write_flag          <= cfg_data;
				rtcsm_pkg::CFG_PROTECT_COMMAND:     cfg_q.protect_command     <= cfg_data;
				rtcsm_pkg::CFG_PROTECT_SET_VALUE:   cfg_q.protect_set_value   <= cfg_data;
				rtcsm_pkg::CFG_PROTECT_CLEAR_VALUE: cfg_q.protect_clear_value <= cfg_data;
				rtcsm_pkg::CFG_BURST_COMMAND:       cfg_q.burst_command       <= cfg_data;
				rtcsm_pkg::CFG_HALF_PERIOD_TICKS:   cfg_q.half_period_ticks   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> design/rtcsm_seq.sv
// ----------------------------------------------------------------------------
// rtcsm_seq
// Pin sequencer: advances the transaction state by one tick per step and
// forms the pin levels and status of that tick.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rtcsm_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step_en,
	input  rtcsm_pkg::tick_t  item,
	input  rtcsm_pkg::cfg_t   cfg,
	output rtcsm_pkg::pins_t  res
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_CMD_HI,
		PH_CMD_LO,
		PH_WR_HI,
		PH_WR_LO,
		PH_RD_LO,
		PH_RD_HI,
		PH_GAP
	} phase_t;

	// Sub-transactions of one request.
	localparam logic [1:0] SUB_CLEAR = 2'd0;
	localparam logic [1:0] SUB_DATA  = 2'd1;
	localparam logic [1:0] SUB_SET   = 2'd2;

	localparam logic [3:0] MAX_BYTES = 4'(rtcsm_pkg::MAX_BURST_BYTES);

	function automatic logic [7:0] sub_command(input logic [1:0] s, input logic [1:0] o,
			input logic [7:0] a, input rtcsm_pkg::cfg_t c);
		logic [7:0] target;
		logic [7:0] flag;
		target = o[rtcsm_pkg::OP_BURST_BIT] ? c.burst_command : a;
		flag   = o[rtcsm_pkg::OP_WRITE_BIT] ? c.write_flag : c.read_flag;
		if (s != SUB_DATA) begin
			return c.write_flag | c.protect_command;
		end
		return target | flag;
	endfunction

	phase_t      phase_q;
	logic [1:0]  sub_q;
	logic [2:0]  bit_q;
	logic [3:0]  byte_q;
	logic [7:0]  shift_q;
	logic [7:0]  tick_q;
	logic [1:0]  op_q;
	logic [7:0]  addr_q;
	logic [3:0]  count_q;
	logic [63:0] wbytes_q;
	logic [63:0] gather_q;

	phase_t      ph;
	logic [1:0]  sub;
	logic [2:0]  bi;
	logic [3:0]  by;
	logic [7:0]  sh;
	logic [7:0]  tk;
	logic [1:0]  op;
	logic [7:0]  ad;
	logic [3:0]  ct;
	logic [63:0] wb;
	logic [63:0] gb;
	logic [7:0]  half;
	logic [3:0]  nb;
	logic        is_read;
	logic        fin;
	logic        start;

	always_comb begin
		ph  = phase_q;
		sub = sub_q;
		bi  = bit_q;
		by  = byte_q;
		sh  = shift_q;
		tk  = tick_q;
		op  = op_q;
		ad  = addr_q;
		ct  = count_q;
		wb  = wbytes_q;
		gb  = gather_q;
		fin = 1'b0;
		res = '0;

		// A request taken while idle shows its first phase on the same tick.
		start = (phase_q == PH_IDLE) && item.start_req;
		if (start) begin
			ct  = (item.count > MAX_BYTES) ? MAX_BYTES : item.count;
			op  = item.op;
			ad  = item.address;
			wb  = item.write_data;
			gb  = '0;
			tk  = '0;
			sub = op[rtcsm_pkg::OP_WRITE_BIT] ? SUB_CLEAR : SUB_DATA;
			sh  = sub_command(sub, op, ad, cfg);
			bi  = '0;
			by  = '0;
			ph  = PH_CMD_HI;
		end

		half    = (cfg.half_period_ticks == 8'd0) ? 8'd1 : cfg.half_period_ticks;
		is_read = (sub == SUB_DATA) && !op[rtcsm_pkg::OP_WRITE_BIT];
		nb      = ((sub != SUB_DATA) || !op[rtcsm_pkg::OP_BURST_BIT]) ? 4'd1 : ct;

		if (ph != PH_IDLE) begin
			res.busy_res = 1'b1;
			case (ph)
				PH_CMD_HI, PH_WR_HI: begin
					res.chip_enable  = 1'b1;
					res.serial_clock = 1'b1;
					res.data_drive   = 1'b1;
					res.data_pin_out = sh[0];
				end
				PH_CMD_LO, PH_WR_LO: begin
					res.chip_enable  = 1'b1;
					res.data_drive   = 1'b1;
					res.data_pin_out = sh[0];
				end
				PH_RD_LO: begin
					res.chip_enable = 1'b1;
				end
				PH_RD_HI: begin
					res.chip_enable  = 1'b1;
					res.serial_clock = 1'b1;
				end
				default: begin
				end
			endcase

			if (9'(tk) + 9'd1 >= 9'(half)) begin
				tk = '0;
				unique case (ph)
					PH_CMD_HI: begin
						// Reads skip the low half of the last command bit and go straight to the read phases.
						if (is_read && bi == 3'd7) begin
							bi = '0;
							by = '0;
							sh = '0;
							if (nb == 4'd0) begin
								fin = 1'b1;
							end else begin
								ph = PH_RD_LO;
							end
						end else begin
							ph = PH_CMD_LO;
						end
					end
					PH_CMD_LO: begin
						sh = sh >> 1;
						if (bi == 3'd7) begin
							bi = '0;
							by = '0;
							if (nb == 4'd0) begin
								fin = 1'b1;
							end else begin
								if (sub == SUB_CLEAR) begin
									sh = cfg.protect_clear_value;
								end else if (sub == SUB_SET) begin
									sh = cfg.protect_set_value;
								end else begin
									sh = wb[7:0];
								end
								ph = PH_WR_HI;
							end
						end else begin
							bi = bi + 3'd1;
							ph = PH_CMD_HI;
						end
					end
					PH_WR_HI: begin
						ph = PH_WR_LO;
					end
					PH_WR_LO: begin
						sh = sh >> 1;
						if (bi == 3'd7) begin
							bi = '0;
							by = by + 4'd1;
							if (by >= nb) begin
								fin = 1'b1;
							end else begin
								if (sub == SUB_CLEAR) begin
									sh = cfg.protect_clear_value;
								end else if (sub == SUB_SET) begin
									sh = cfg.protect_set_value;
								end else begin
									sh = wb[{by[2:0], 3'b000} +: 8];
								end
								ph = PH_WR_HI;
							end
						end else begin
							bi = bi + 3'd1;
							ph = PH_WR_HI;
						end
					end
					PH_RD_LO: begin
						sh = {item.data_pin_in, sh[7:1]};
						ph = PH_RD_HI;
					end
					PH_RD_HI: begin
						ph = PH_RD_LO;
						if (bi == 3'd7) begin
							gb[{by[2:0], 3'b000} +: 8] = gb[{by[2:0], 3'b000} +: 8] | sh;
							bi = '0;
							sh = '0;
							by = by + 4'd1;
							if (by >= nb) begin
								fin = 1'b1;
							end
						end else begin
							bi = bi + 3'd1;
						end
					end
					PH_GAP: begin
						sub = sub + 2'd1;
						sh  = sub_command(sub, op, ad, cfg);
						bi  = '0;
						by  = '0;
						ph  = PH_CMD_HI;
					end
					default: begin
						ph = PH_IDLE;
					end
				endcase

				// End of a sub-transaction: a write goes on after a short gap.
				if (fin) begin
					if (op[rtcsm_pkg::OP_WRITE_BIT] && sub < SUB_SET) begin
						ph = PH_GAP;
					end else begin
						ph  = PH_IDLE;
						sub = SUB_CLEAR;
						bi  = '0;
						by  = '0;
						res.done_res = 1'b1;
					end
				end
			end else begin
				tk = tk + 8'd1;
			end
		end

		res.read_data = gb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			sub_q    <= SUB_CLEAR;
			bit_q    <= '0;
			byte_q   <= '0;
			shift_q  <= '0;
			tick_q   <= '0;
			op_q     <= '0;
			addr_q   <= '0;
			count_q  <= '0;
			wbytes_q <= '0;
			gather_q <= '0;
		end else if (step_en) begin
			phase_q  <= ph;
			sub_q    <= sub;
			bit_q    <= bi;
			byte_q   <= by;
			shift_q  <= sh;
			tick_q   <= tk;
			op_q     <= op;
			addr_q   <= ad;
			count_q  <= ct;
			wbytes_q <= wb;
			gather_q <= gb;
		end
	end

	`ASSERT_SAME_CYCLE(a_idle_clean, clk, arst_n, phase_q == PH_IDLE, (sub_q == SUB_CLEAR) && (bit_q == 3'd0) && (byte_q == 4'd0))
	`ASSERT_SAME_CYCLE(a_read_only_data, clk, arst_n, (phase_q == PH_RD_LO) || (phase_q == PH_RD_HI), (sub_q == SUB_DATA) && !op_q[rtcsm_pkg::OP_WRITE_BIT])
	`ASSERT_SAME_CYCLE(a_byte_bound, clk, arst_n, 1'b1, byte_q <= MAX_BYTES)
	`ASSERT_NEXT_CYCLE(a_start_leaves_idle, clk, arst_n, step_en && (phase_q == PH_IDLE) && item.start_req, phase_q != PH_IDLE)

endmodule

>>> design/three_wire_rtc_serial_master_unit.sv
// An item accepted at a clock edge is taken into the input register; its result item is
// loaded into the output register once that register is free. Without output stalls,
// throughput is one item per clock cycle; each item advances the pin sequencer by one tick.
// Reset (arst_n low, asynchronous): both channel stages empty, sequencer idle, all
// configuration registers at their documented defaults, gathered read bytes zero.
// ----------------------------------------------------------------------------
// three_wire_rtc_serial_master_unit
// Three-wire serial master (chip enable, clock, bidirectional data) for a
// serial clock chip, stepped by one time tick per item.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module three_wire_rtc_serial_master_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [rtcsm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [7:0]                       cfg_data,
	rtcsm_tick_if.sink                       tick,
	rtcsm_pins_if.source                     pins
);

	// The design is a two-register pipe. The input register holds one tick item;
	// the sequencer works that item against its state in one pass of logic, and
	// the outcome lands in the output register. Both registers move together
	// whenever the output register is empty or being drained, so a new item is
	// taken every cycle while the downstream side keeps up.

	rtcsm_pkg::cfg_t   cfg;
	rtcsm_pkg::tick_t  item_s1;
	logic              valid_s1;
	rtcsm_pkg::pins_t  res_comb;
	rtcsm_pkg::pins_t  res_s2;
	logic              valid_s2;
	logic              adv;
	logic              step_en;

	rtcsm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// The pipe advances when the output register can take a new result.
	assign adv        = !valid_s2 || pins.ready;
	assign tick.ready = !valid_s1 || adv;
	// The sequencer state only moves when a real item leaves the input register.
	assign step_en    = valid_s1 && adv;

	rtcsm_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (step_en),
		.item    (item_s1),
		.cfg     (cfg),
		.res     (res_comb)
	);

	// Valid flags of both stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (tick.valid && tick.ready) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			item_s1 <= tick.data;
		end
		if (step_en) begin
			res_s2 <= res_comb;
		end
	end

	assign pins.valid = valid_s2;
	assign pins.data  = res_s2;

	// A finishing tick always belongs to a running transaction.
	`ASSERT_SAME_CYCLE(a_done_while_busy, clk, arst_n, valid_s2 && res_s2.done_res, res_s2.busy_res)
	// Input is only refused while an item sits waiting in the input register.
	`ASSERT_SAME_CYCLE(a_stall_has_item, clk, arst_n, !tick.ready, valid_s1 && valid_s2)

endmodule

>>> bench/rtcsm_pin_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtcsm_pin_checker
// Watches the tick and pin channels of the three-wire serial master. It keeps
// its own copy of the configuration and sequencer state, works out the pin
// levels of every accepted tick item and compares each returned item with
// the oldest prediction.
// ----------------------------------------------------------------------------
module rtcsm_pin_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [rtcsm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                      cfg_data,
	rtcsm_tick_if                           tick,
	rtcsm_pins_if                           pins,
	output int unsigned                     fail_count,
	output int unsigned                     pending,
	output logic                            seq_idle,
	output int unsigned                     checked_count,
	output int unsigned                     done_count
);
	import rtcsm_pkg::*;

	typedef enum logic [4:0] {
		SEQ_IDLE,
		SEQ_CMD_HI,
		SEQ_CMD_LO,
		SEQ_WR_HI,
		SEQ_WR_LO,
		SEQ_RD_LO,
		SEQ_RD_HI,
		SEQ_GAP
	} seq_phase_t;

	// Sub-transactions of one request; reads run only the data one.
	localparam logic [1:0] SUB_CLEAR = 2'd0;
	localparam logic [1:0] SUB_DATA  = 2'd1;
	localparam logic [1:0] SUB_SET   = 2'd2;

	cfg_t        regs;
	seq_phase_t  seq_phase;
	logic [1:0]  seq_sub;
	logic [2:0]  seq_bit;
	logic [3:0]  seq_byte;
	logic [7:0]  seq_shift;
	logic [7:0]  seq_ticks;
	logic [1:0]  req_op;
	logic [7:0]  req_addr;
	logic [3:0]  req_count;
	logic [63:0] req_wr_bytes;
	logic [63:0] rd_bytes;
	pins_t       expected_pins[$];

	function automatic logic is_read_sub();
		return seq_sub == SUB_DATA && !req_op[OP_WRITE_BIT];
	endfunction

	function automatic logic [7:0] sub_command_byte();
		logic [7:0] target;
		if (seq_sub != SUB_DATA)
			return regs.write_flag | regs.protect_command;
		target = req_op[OP_BURST_BIT] ? regs.burst_command : req_addr;
		return target | (req_op[OP_WRITE_BIT] ? regs.write_flag : regs.read_flag);
	endfunction

	function automatic int unsigned sub_byte_total();
		if (seq_sub != SUB_DATA || !req_op[OP_BURST_BIT])
			return 1;
		return req_count;
	endfunction

	function automatic logic [7:0] outgoing_byte(input logic [3:0] idx);
		if (seq_sub == SUB_CLEAR)
			return regs.protect_clear_value;
		if (seq_sub == SUB_SET)
			return regs.protect_set_value;
		return req_wr_bytes[8 * idx[2:0] +: 8];
	endfunction

	function automatic void start_sub();
		seq_shift = sub_command_byte();
		seq_bit = 3'd0;
		seq_byte = 4'd0;
		seq_phase = SEQ_CMD_HI;
	endfunction

	// Returns 1 when the whole request is over.
	function automatic logic finish_sub();
		if (req_op[OP_WRITE_BIT] && seq_sub < SUB_SET) begin
			seq_phase = SEQ_GAP;
			return 1'b0;
		end
		seq_phase = SEQ_IDLE;
		seq_sub = SUB_CLEAR;
		seq_bit = 3'd0;
		seq_byte = 4'd0;
		return 1'b1;
	endfunction

	function automatic logic advance_phase(input logic pin);
		case (seq_phase)
			SEQ_CMD_HI: begin
				if (is_read_sub() && seq_bit == 3'd7) begin
					seq_bit = 3'd0;
					seq_byte = 4'd0;
					seq_shift = 8'd0;
					if (sub_byte_total() == 0)
						return finish_sub();
					seq_phase = SEQ_RD_LO;
				end else begin
					seq_phase = SEQ_CMD_LO;
				end
			end
			SEQ_CMD_LO: begin
				seq_shift = seq_shift >> 1;
				if (seq_bit == 3'd7) begin
					seq_bit = 3'd0;
					seq_byte = 4'd0;
					if (sub_byte_total() == 0)
						return finish_sub();
					seq_shift = outgoing_byte(4'd0);
					seq_phase = SEQ_WR_HI;
				end else begin
					seq_bit = seq_bit + 3'd1;
					seq_phase = SEQ_CMD_HI;
				end
			end
			SEQ_WR_HI: begin
				seq_phase = SEQ_WR_LO;
			end
			SEQ_WR_LO: begin
				seq_shift = seq_shift >> 1;
				if (seq_bit == 3'd7) begin
					seq_bit = 3'd0;
					seq_byte = seq_byte + 4'd1;
					if (seq_byte >= sub_byte_total())
						return finish_sub();
					seq_shift = outgoing_byte(seq_byte);
				end else begin
					seq_bit = seq_bit + 3'd1;
				end
				seq_phase = SEQ_WR_HI;
			end
			SEQ_RD_LO: begin
				seq_shift = {pin, seq_shift[7:1]};
				seq_phase = SEQ_RD_HI;
			end
			SEQ_RD_HI: begin
				if (seq_bit == 3'd7) begin
					rd_bytes = rd_bytes | (64'(seq_shift) << (8 * seq_byte[2:0]));
					seq_bit = 3'd0;
					seq_shift = 8'd0;
					seq_byte = seq_byte + 4'd1;
					if (seq_byte >= sub_byte_total())
						return finish_sub();
				end else begin
					seq_bit = seq_bit + 3'd1;
				end
				seq_phase = SEQ_RD_LO;
			end
			SEQ_GAP: begin
				seq_sub = seq_sub + 2'd1;
				start_sub();
			end
			default: begin
				seq_phase = SEQ_IDLE;
			end
		endcase
		return 1'b0;
	endfunction

	function automatic pins_t predict_tick(input tick_t t);
		pins_t      r;
		int         half;
		logic [3:0] cnt;
		r = '0;
		half = (regs.half_period_ticks == 8'd0) ? 1 : int'(regs.half_period_ticks);
		if (seq_phase == SEQ_IDLE && t.start_req) begin
			cnt = (t.count > MAX_BURST_BYTES) ? 4'(MAX_BURST_BYTES) : t.count;
			req_op = t.op;
			req_addr = t.address;
			req_count = cnt;
			req_wr_bytes = t.write_data;
			rd_bytes = 64'd0;
			seq_ticks = 8'd0;
			seq_sub = t.op[OP_WRITE_BIT] ? SUB_CLEAR : SUB_DATA;
			start_sub();
		end
		if (seq_phase != SEQ_IDLE) begin
			r.busy_res = 1'b1;
			case (seq_phase)
				SEQ_CMD_HI, SEQ_WR_HI: begin
					r.chip_enable = 1'b1;
					r.serial_clock = 1'b1;
					r.data_drive = 1'b1;
					r.data_pin_out = seq_shift[0];
				end
				SEQ_CMD_LO, SEQ_WR_LO: begin
					r.chip_enable = 1'b1;
					r.data_drive = 1'b1;
					r.data_pin_out = seq_shift[0];
				end
				SEQ_RD_LO: begin
					r.chip_enable = 1'b1;
				end
				SEQ_RD_HI: begin
					r.chip_enable = 1'b1;
					r.serial_clock = 1'b1;
				end
				default: begin
				end
			endcase
			if (int'(seq_ticks) + 1 >= half) begin
				seq_ticks = 8'd0;
				r.done_res = advance_phase(t.data_pin_in);
			end else begin
				seq_ticks = seq_ticks + 8'd1;
			end
		end
		r.read_data = rd_bytes;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [63:0] exp_v,
			input logic [63:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		pins_t exp_p;
		if (!arst_n) begin
			regs = '{read_flag: RST_READ_FLAG, write_flag: RST_WRITE_FLAG,
				protect_command: RST_PROTECT_COMMAND,
				protect_set_value: RST_PROTECT_SET_VALUE,
				protect_clear_value: RST_PROTECT_CLEAR_VALUE,
				burst_command: RST_BURST_COMMAND,
				half_period_ticks: RST_HALF_PERIOD_TICKS};
			seq_phase = SEQ_IDLE;
			seq_sub = SUB_CLEAR;
			seq_bit = 3'd0;
			seq_byte = 4'd0;
			seq_shift = 8'd0;
			seq_ticks = 8'd0;
			req_op = 2'd0;
			req_addr = 8'd0;
			req_count = 4'd0;
			req_wr_bytes = 64'd0;
			rd_bytes = 64'd0;
			expected_pins.delete();
			fail_count = 0;
			checked_count = 0;
			done_count = 0;
			pending = 0;
			seq_idle = 1'b1;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_READ_FLAG:           regs.read_flag = cfg_data;
					CFG_WRITE_FLAG:          regs.write_flag = cfg_data;
					CFG_PROTECT_COMMAND:     regs.protect_command = cfg_data;
					CFG_PROTECT_SET_VALUE:   regs.protect_set_value = cfg_data;
					CFG_PROTECT_CLEAR_VALUE: regs.protect_clear_value = cfg_data;
					CFG_BURST_COMMAND:       regs.burst_command = cfg_data;
					CFG_HALF_PERIOD_TICKS:   regs.half_period_ticks = cfg_data;
					default: begin
					end
				endcase
			end
			if (tick.valid && tick.ready)
				expected_pins.push_back(predict_tick(tick.data));
			if (pins.valid && pins.ready) begin
				if (expected_pins.size() == 0) begin
					$error("pin item arrived with no prediction waiting");
					fail_count++;
				end else begin
					exp_p = expected_pins.pop_front();
					check_field("chip_enable", exp_p.chip_enable, pins.data.chip_enable);
					check_field("serial_clock", exp_p.serial_clock, pins.data.serial_clock);
					check_field("data_pin_out", exp_p.data_pin_out, pins.data.data_pin_out);
					check_field("data_drive", exp_p.data_drive, pins.data.data_drive);
					check_field("busy_res", exp_p.busy_res, pins.data.busy_res);
					check_field("done_res", exp_p.done_res, pins.data.done_res);
					check_field("read_data", exp_p.read_data, pins.data.read_data);
					checked_count++;
					if (exp_p.done_res)
						done_count++;
				end
			end
			pending = expected_pins.size();
			seq_idle = (seq_phase == SEQ_IDLE);
		end
	end

endmodule

>>> bench/tb_three_wire_rtc_serial_master_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_three_wire_rtc_serial_master_unit
// Drives tick items into the three-wire serial master and collects its pin
// items under several backpressure patterns and register settings. A checker
// beside the block predicts every pin item; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_three_wire_rtc_serial_master_unit;
	import rtcsm_pkg::*;

	// Only catches a hang; a normal run ends long before this limit.
	localparam int unsigned CYCLE_LIMIT  = 100_000;
	// Noisy ticks sent at the end, after the directed requests.
	localparam int unsigned RANDOM_TICKS = 150;

	// Request kinds carried in the op field.
	localparam logic [1:0] OP_READ_SINGLE  = 2'd0;
	localparam logic [1:0] OP_READ_BURST   = 2'd1;
	localparam logic [1:0] OP_WRITE_SINGLE = 2'd2;
	localparam logic [1:0] OP_WRITE_BURST  = 2'd3;

	// How the data line answers while a request runs.
	localparam int PINS_RANDOM = 0;
	localparam int PINS_HIGH   = 1;
	localparam int PINS_LOW    = 2;

	// Idling phases: none, sender idle, receiver stall, both.
	localparam int unsigned IDLE_NONE   = 0;
	localparam int unsigned IDLE_SENDER = 1;
	localparam int unsigned IDLE_SINK   = 2;
	localparam int unsigned IDLE_BOTH   = 3;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [7:0]           cfg_data;

	rtcsm_tick_if tick_ch ();
	rtcsm_pins_if pins_ch ();

	int unsigned fail_count;
	int unsigned pending;
	logic        seq_idle;
	int unsigned checked_count;
	int unsigned done_count;

	// Idle and stall chances in percent, changed from phase to phase.
	int unsigned src_idle_pct   = 0;
	int unsigned sink_stall_pct = 0;
	int unsigned requests_sent  = 0;
	int unsigned ticks_sent     = 0;
	int unsigned settings_done  = 0;
	int unsigned cycles;

	// Percent chances per idling phase: none, sender idle, receiver stall, both.
	int unsigned src_idle_by_phase[4]   = '{0, 73, 0, 11};
	int unsigned sink_stall_by_phase[4] = '{0, 0, 73, 11};

	three_wire_rtc_serial_master_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.tick      (tick_ch),
		.pins      (pins_ch)
	);

	rtcsm_pin_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.tick          (tick_ch),
		.pins          (pins_ch),
		.fail_count    (fail_count),
		.pending       (pending),
		.seq_idle      (seq_idle),
		.checked_count (checked_count),
		.done_count    (done_count)
	);

	// 20 ns clock, low for the first half period.
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// The receiver decides its ready level at every falling edge, so the block
	// sees stalls land on any phase of its output register.
	initial begin
		pins_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			pins_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// Watchdog: ends a run that stops making progress.
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("end of test: mismatches");
		$finish;
	end

	task automatic set_idling(input int unsigned phase_sel);
		src_idle_pct = src_idle_by_phase[phase_sel];
		sink_stall_pct = sink_stall_by_phase[phase_sel];
	endtask

	// Offers one tick item, with random idle cycles in front of it, and returns
	// at the falling edge after it was accepted. Valid stays high on return so
	// that back-to-back items need only one assignment per edge; a caller that
	// stops sending lowers it with release_source.
	task automatic send_tick(input tick_t t);
		while ($urandom_range(99) < src_idle_pct) begin
			tick_ch.valid <= 1'b0;
			@(negedge clk);
		end
		tick_ch.valid <= 1'b1;
		tick_ch.data <= t;
		@(posedge clk);
		while (!tick_ch.ready)
			@(posedge clk);
		ticks_sent++;
		@(negedge clk);
	endtask

	task automatic release_source();
		tick_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	// Stops the sender until every predicted pin item has come back. Every
	// item yields exactly one result; the extra wait after that is only a margin.
	task automatic wait_drained();
		release_source();
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
	endtask

	// Registers change only while no item is in flight.
	task automatic apply_cfg(input cfg_t c);
		wait_drained();
		write_reg(CFG_READ_FLAG, c.read_flag);
		write_reg(CFG_WRITE_FLAG, c.write_flag);
		write_reg(CFG_PROTECT_COMMAND, c.protect_command);
		write_reg(CFG_PROTECT_SET_VALUE, c.protect_set_value);
		write_reg(CFG_PROTECT_CLEAR_VALUE, c.protect_clear_value);
		write_reg(CFG_BURST_COMMAND, c.burst_command);
		write_reg(CFG_HALF_PERIOD_TICKS, c.half_period_ticks);
		cfg_we <= 1'b0;
		@(negedge clk);
		settings_done++;
	endtask

	function automatic tick_t make_request(input logic [1:0] op, input logic [7:0] addr,
			input logic [3:0] cnt, input logic [63:0] wdata);
		tick_t t;
		t.start_req = 1'b1;
		t.op = op;
		t.address = addr;
		t.count = cnt;
		t.write_data = wdata;
		t.data_pin_in = 1'($urandom_range(1));
		return t;
	endfunction

	// A tick that only advances the sequencer. Noisy ticks also raise
	// start_req while a request is running, which the block must ignore.
	function automatic tick_t filler_tick(input bit noisy, input int pin_mode);
		tick_t t;
		t.start_req = noisy ? 1'($urandom_range(1)) : 1'b0;
		t.op = 2'($urandom_range(3));
		t.address = 8'($urandom_range(255));
		t.count = 4'($urandom_range(15));
		t.write_data = {$urandom, $urandom};
		case (pin_mode)
			PINS_HIGH: t.data_pin_in = 1'b1;
			PINS_LOW:  t.data_pin_in = 1'b0;
			default:   t.data_pin_in = 1'($urandom_range(1));
		endcase
		return t;
	endfunction

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(4))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// Half periods stay small so that many requests complete; zero must act
	// as one.
	function automatic cfg_t random_cfg();
		cfg_t c;
		c.read_flag = pick_byte();
		c.write_flag = pick_byte();
		c.protect_command = pick_byte();
		c.protect_set_value = pick_byte();
		c.protect_clear_value = pick_byte();
		c.burst_command = pick_byte();
		c.half_period_ticks = ($urandom_range(9) == 0) ? 8'($urandom_range(4, 6))
			: 8'($urandom_range(3));
		return c;
	endfunction

	// Runs one request to its end: the start item, then ticks until the
	// sequencer is idle again. When pause_at is nonzero the sender stops after
	// that many ticks and lets every pending result drain mid-request.
	task automatic run_request(input tick_t req, input int pin_mode, input bit noisy,
			input int unsigned pause_at);
		int unsigned n;
		n = 0;
		send_tick(req);
		requests_sent++;
		while (!seq_idle) begin
			n++;
			if (n == pause_at)
				wait_drained();
			send_tick(filler_tick(noisy, pin_mode));
		end
	endtask

	initial begin
		tick_ch.valid = 1'b0;
		tick_ch.data = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_READ_FLAG;
		cfg_data = 8'd0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// No idling, reset register values. An idle tick with no request
		// comes first.
		set_idling(IDLE_NONE);
		send_tick(filler_tick(1'b0, PINS_RANDOM));
		run_request(make_request(OP_READ_SINGLE, 8'h00, 4'd0, '0), PINS_LOW, 1'b0, 0);
		// The sender pauses in the middle of this read until all results are in.
		run_request(make_request(OP_READ_SINGLE, 8'hFF, 4'd15, '1), PINS_HIGH, 1'b0, 7);
		// A burst of zero bytes sends only the command byte.
		run_request(make_request(OP_READ_BURST, 8'h00, 4'd0, '0), PINS_RANDOM, 1'b0, 0);

		// Sender idling. Counts above the burst size saturate.
		set_idling(IDLE_SENDER);
		run_request(make_request(OP_READ_BURST, 8'h34, 4'd15, '0), PINS_RANDOM, 1'b0, 0);
		run_request(make_request(OP_WRITE_BURST, 8'h56, 4'd0, '1), PINS_RANDOM, 1'b0, 0);

		// Receiver stalling: a single write, then all-ones flags and protect
		// bytes with a zero half period.
		set_idling(IDLE_SINK);
		run_request(make_request(OP_WRITE_SINGLE, 8'h80, 4'd3, 64'hFFFF_FFFF_FFFF_FFA5),
			PINS_RANDOM, 1'b0, 0);
		apply_cfg('{read_flag: 8'hFF, write_flag: 8'hFF, protect_command: 8'h00,
			protect_set_value: 8'hFF, protect_clear_value: 8'hFF, burst_command: 8'h00,
			half_period_ticks: 8'h00});
		run_request(make_request(OP_READ_SINGLE, 8'h55, 4'd0, '0), PINS_RANDOM, 1'b1, 0);

		// Both sides idling. Two ticks per phase, so reads sample on the second
		// tick of each low phase.
		set_idling(IDLE_BOTH);
		apply_cfg('{read_flag: RST_READ_FLAG, write_flag: RST_WRITE_FLAG,
			protect_command: RST_PROTECT_COMMAND, protect_set_value: RST_PROTECT_SET_VALUE,
			protect_clear_value: RST_PROTECT_CLEAR_VALUE, burst_command: RST_BURST_COMMAND,
			half_period_ticks: 8'd2});
		run_request(make_request(OP_READ_SINGLE, 8'h81, 4'd0, '0), PINS_RANDOM, 1'b1, 0);

		// Random register settings and a stream of noisy ticks, whose start
		// requests launch random transfers whenever the sequencer is idle.
		apply_cfg(random_cfg());
		repeat (RANDOM_TICKS) send_tick(filler_tick(1'b1, PINS_RANDOM));

		// Let the last results arrive, plus a margin for anything stray.
		wait_drained();
		repeat (8) @(negedge clk);

		$display("Run sent %0d tick items: %0d directed requests and a noisy random stream,",
			ticks_sent, requests_sent);
		$display("over %0d register settings and four idling phases; %0d pin items checked.",
			settings_done, checked_count);
		$display("Transactions completed: %0d.", done_count);
		if (fail_count == 0 && pending == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
